### sv/rscl_pkg.sv
// ============================================================================
// rscl_pkg
// Shared types, constants and ranking functions for the ranked sorted card
// list.
// ============================================================================
`default_nettype none

package rscl_pkg;

    // list geometry
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // ranking tables
    localparam int NUM_VALUE_SLOTS = 13;
    localparam int NUM_SUIT_SLOTS  = 4;
    localparam int VALUE_W         = 4;
    localparam int SUIT_W          = 2;
    localparam int VORDER_W        = NUM_VALUE_SLOTS * VALUE_W;
    localparam int SORDER_W        = NUM_SUIT_SLOTS * SUIT_W;
    localparam int NRV_W           = 4;
    localparam int CFG_DATA_W      = VORDER_W;
    localparam int CFG_INDEX_W     = 2;

    // port field widths
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

    // register reset values
    localparam logic [VORDER_W-1:0] VALUE_ORDER_RESET = 52'hCBA9876543210;
    localparam logic [SORDER_W-1:0] SUIT_ORDER_RESET  = 8'hE4;
    localparam logic [NRV_W-1:0]    NUM_RANKED_RESET  = 4'd13;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_ORDER = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SUIT_ORDER  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_RANKED  = 2'd2;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT     = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE_ONE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE_ALL = 2'd2;
    localparam logic [FUNC_W-1:0] FN_READ       = 2'd3;

    // one stored card
    typedef struct packed {
        logic [SUIT_W-1:0]  suit;
        logic [VALUE_W-1:0] value;
    } card_t;

    // command item
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] card_value;
        logic [SUIT_W-1:0]  card_suit;
        logic [POS_W-1:0]   position;
    } cmd_t;

    // response item
    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] entry_count;
        logic [VALUE_W-1:0] read_value;
        logic [SUIT_W-1:0]  read_suit;
        logic [COUNT_W-1:0] removed_count;
    } rsp_t;

    // first ranked slot holding the value code, zero if none
    function automatic logic [VALUE_W-1:0] value_rank(
        input logic [VALUE_W-1:0]  v,
        input logic [VORDER_W-1:0] order,
        input logic [NRV_W-1:0]    n
    );
        logic [VALUE_W-1:0] rank;
        rank = '0;
        for (int k = NUM_VALUE_SLOTS - 1; k >= 0; k--)
        begin
            if ((NRV_W'(k) < n) && (order[k*VALUE_W +: VALUE_W] == v))
            begin
                rank = VALUE_W'(k);
            end
        end
        return rank;
    endfunction

    // first suit slot holding the suit code, zero if none
    function automatic logic [SUIT_W-1:0] suit_rank(
        input logic [SUIT_W-1:0]   s,
        input logic [SORDER_W-1:0] order
    );
        logic [SUIT_W-1:0] rank;
        rank = '0;
        for (int k = NUM_SUIT_SLOTS - 1; k >= 0; k--)
        begin
            if (order[k*SUIT_W +: SUIT_W] == s)
            begin
                rank = SUIT_W'(k);
            end
        end
        return rank;
    endfunction

endpackage

`default_nettype wire

### sv/rscl_if.sv
// ============================================================================
// rscl_if
// Valid/ready channels carrying command and response items.
// ============================================================================
`default_nettype none

interface rscl_cmd_if;
    import rscl_pkg::*;

    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rscl_rsp_if;
    import rscl_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/ranked_sorted_card_list.sv
// Insert and remove walk the list from accept to response, read does a single
// memory read, and an insert to a full list goes straight to its response.
// Throughput is one item per operation; one card memory read port, one write port
// and one comparator walk the list one entry per cycle, the block taking no item meanwhile.
// Reset empties the list and restores the default ranking; memory is not cleared.
// ============================================================================
// ranked_sorted_card_list
// Bounded list of cards kept in ascending order under a configurable ranking,
// with insert, remove first equal, remove all equal and read by position.
// ============================================================================
`default_nettype none

module ranked_sorted_card_list (
    input  wire                                clk,
    input  wire                                rst_n,
    rscl_cmd_if.sink                           cmd,
    rscl_rsp_if.source                         rsp,
    input  wire                                cfg_wr_en,
    input  wire [rscl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire [rscl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rscl_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // ranking registers
    logic [VORDER_W-1:0] vorder_reg;
    logic [SORDER_W-1:0] sorder_reg;
    logic [NRV_W-1:0]    nrv_reg;

    // sequencer and operation state
    logic [1:0]          state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg;
    card_t               card_reg;
    logic [VALUE_W-1:0]  cvr_reg;
    logic [SUIT_W-1:0]   csr_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                full_reg;
    logic [CNT_W-1:0]    len_reg, len_next;
    logic [CNT_W-1:0]    rd_cnt_reg;
    logic                pend_reg;
    logic [IDX_W-1:0]    idx_reg;
    card_t               held_reg, held_next;
    logic                found_reg, found_next;
    logic [CNT_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]    removed_reg, removed_next;

    // card memory
    card_t               mem [CAPACITY];
    card_t               rd_data_reg;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    card_t               wr_data;

    // output register
    logic                out_valid_reg;
    rsp_t                out_data_reg;
    rsp_t                res;
    logic                out_free;
    logic                cmd_acc;
    logic                issue;

    // shared comparator
    logic [VALUE_W-1:0]  e_vr;
    logic [SUIT_W-1:0]   e_sr;
    logic                same_val;
    logic                cmp_lt;
    logic                cmp_eq;
    logic                do_remove;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // compare the command's card against the entry just read
    assign e_vr     = value_rank(rd_data_reg.value, vorder_reg, nrv_reg);
    assign e_sr     = suit_rank(rd_data_reg.suit, sorder_reg);
    assign same_val = (card_reg.value == rd_data_reg.value);
    assign cmp_lt   = same_val ? (csr_reg < e_sr) : (cvr_reg < e_vr);
    assign cmp_eq   = same_val ? (csr_reg == e_sr) : (cvr_reg == e_vr);
    assign do_remove = cmp_eq && ((func_reg == FN_REMOVE_ALL) || (removed_reg == '0));

    // read issue during the walk
    assign issue = (state_reg == ST_SCAN) && (rd_cnt_reg < len_reg);

    // memory port control and walk bookkeeping
    always_comb
    begin
        rd_en        = 1'b0;
        rd_addr      = IDX_W'(rd_cnt_reg);
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = card_reg;
        held_next    = held_reg;
        found_next   = found_reg;
        wr_ptr_next  = wr_ptr_reg;
        removed_next = removed_reg;
        state_next   = state_reg;
        len_next     = len_reg;
        res          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    if (cmd.data.func == FN_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if ((cmd.data.func == FN_INSERT) && (len_reg == CNT_W'(CAPACITY)))
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_en = issue;
                if (pend_reg)
                begin
                    if (func_reg == FN_INSERT)
                    begin
                        // ripple entries up by one from the insertion point
                        if (!found_reg)
                        begin
                            if (cmp_lt)
                            begin
                                wr_en      = 1'b1;
                                wr_data    = card_reg;
                                held_next  = rd_data_reg;
                                found_next = 1'b1;
                            end
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_data   = held_reg;
                            held_next = rd_data_reg;
                        end
                    end
                    else
                    begin
                        // compact the list, dropping the first matching entry or all of them
                        if (do_remove)
                        begin
                            removed_next = removed_reg + 1'b1;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = IDX_W'(wr_ptr_reg);
                            wr_data     = rd_data_reg;
                            wr_ptr_next = wr_ptr_reg + 1'b1;
                        end
                    end
                end
                if (!issue && !pend_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(pos_reg);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // result and final write
                case (func_reg)
                    FN_INSERT:
                    begin
                        res.ok = !full_reg;
                        if (!full_reg)
                        begin
                            len_next = len_reg + 1'b1;
                            wr_en    = out_free;
                            wr_addr  = IDX_W'(len_reg);
                            wr_data  = found_reg ? held_reg : card_reg;
                        end
                    end
                    FN_READ:
                    begin
                        if (CNT_W'(pos_reg) < len_reg)
                        begin
                            res.ok         = 1'b1;
                            res.read_value = rd_data_reg.value;
                            res.read_suit  = rd_data_reg.suit;
                        end
                    end
                    default:
                    begin
                        res.ok            = (removed_reg != '0);
                        res.removed_count = COUNT_W'(removed_reg);
                        len_next          = wr_ptr_reg;
                    end
                endcase
                res.entry_count = COUNT_W'(len_next);
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    len_next = len_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // card memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // latch the command fields and the card's ranks
    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            func_reg       <= cmd.data.func;
            card_reg.value <= cmd.data.card_value;
            card_reg.suit  <= cmd.data.card_suit;
            cvr_reg        <= value_rank(cmd.data.card_value, vorder_reg, nrv_reg);
            csr_reg        <= suit_rank(cmd.data.card_suit, sorder_reg);
            pos_reg        <= cmd.data.position;
        end
        if (issue)
        begin
            idx_reg <= rd_addr;
        end
        held_reg <= held_next;
    end

    // sequencer and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            rd_cnt_reg  <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            full_reg    <= 1'b0;
            wr_ptr_reg  <= '0;
            removed_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pend_reg  <= issue;
            if (cmd_acc)
            begin
                rd_cnt_reg  <= '0;
                found_reg   <= 1'b0;
                wr_ptr_reg  <= '0;
                removed_reg <= '0;
                full_reg    <= (len_reg == CNT_W'(CAPACITY));
            end
            else
            begin
                if (issue)
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
                found_reg   <= found_next;
                wr_ptr_reg  <= wr_ptr_next;
                removed_reg <= removed_next;
            end
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FIN) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FIN) && out_free)
        begin
            out_data_reg <= res;
        end
    end

    // ranking register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vorder_reg <= VALUE_ORDER_RESET;
            sorder_reg <= SUIT_ORDER_RESET;
            nrv_reg    <= NUM_RANKED_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_VALUE_ORDER: vorder_reg <= cfg_data[VORDER_W-1:0];
                REG_SUIT_ORDER:  sorder_reg <= cfg_data[SORDER_W-1:0];
                REG_NUM_RANKED:  nrv_reg    <= cfg_data[NRV_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### test/card_order_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// card_order_checker
// Watches the command, response and register channels of the card list. It
// keeps its own copy of the ranking registers and of the sorted list, works
// out the response each accepted command should give, and compares every
// accepted response field by field with the oldest one still waiting.
// ============================================================================

module card_order_checker
    import rscl_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cmd_valid,
    input  wire                   cmd_ready,
    input  cmd_t                  cmd_data,
    input  wire                   rsp_valid,
    input  wire                   rsp_ready,
    input  rsp_t                  rsp_data,
    input  wire                   cfg_wr_en,
    input  wire [CFG_INDEX_W-1:0] cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data,
    output int unsigned           outstanding,
    output int unsigned           mismatches
);

    localparam int MAX_REPORTS = 40;

    // shadow ranking registers
    logic [VORDER_W-1:0] value_order;
    logic [SORDER_W-1:0] suit_order;
    logic [NRV_W-1:0]    num_ranked;

    // shadow list and the replies still owed by the block
    card_t       cards [CAPACITY];
    int          list_len;
    rsp_t        awaited_replies [$];
    int unsigned replies_seen;

    initial
    begin
        outstanding  = 0;
        mismatches   = 0;
        replies_seen = 0;
    end

    // one line per mismatch, quiet after the first few
    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
        begin
            $display("%0t card_order_checker: reply %0d: %s", $time, replies_seen, what);
        end
        mismatches++;
    endtask

    // first searched value slot holding the code, zero if none
    function automatic int value_slot_rank(input logic [VALUE_W-1:0] code);
        int limit;
        int k;
        limit = (int'(num_ranked) > NUM_VALUE_SLOTS) ? NUM_VALUE_SLOTS : int'(num_ranked);
        for (k = 0; k < limit; k++)
        begin
            if (value_order[k*VALUE_W +: VALUE_W] == code)
            begin
                return k;
            end
        end
        return 0;
    endfunction

    // first suit slot holding the code, zero if none
    function automatic int suit_slot_rank(input logic [SUIT_W-1:0] code);
        int k;
        for (k = 0; k < NUM_SUIT_SLOTS; k++)
        begin
            if (suit_order[k*SUIT_W +: SUIT_W] == code)
            begin
                return k;
            end
        end
        return 0;
    endfunction

    // signed ordering of two cards: suits decide only between equal value codes
    function automatic int card_compare(input card_t a, input card_t b);
        if (a.value == b.value)
        begin
            return suit_slot_rank(a.suit) - suit_slot_rank(b.suit);
        end
        return value_slot_rank(a.value) - value_slot_rank(b.value);
    endfunction

    // apply one command to the shadow list and build the reply it gives
    function automatic rsp_t apply_list_op(input cmd_t c);
        rsp_t  r;
        card_t card;
        int    i;
        int    j;
        int    removed;
        r          = '0;
        card.value = c.card_value;
        card.suit  = c.card_suit;
        removed    = 0;
        case (c.func)
            FN_INSERT:
            begin
                // a full list turns the card away
                if (list_len < CAPACITY)
                begin
                    i = 0;
                    while (i < list_len && card_compare(card, cards[i]) >= 0)
                    begin
                        i++;
                    end
                    for (j = list_len; j > i; j--)
                    begin
                        cards[j] = cards[j-1];
                    end
                    cards[i] = card;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            FN_REMOVE_ONE:
            begin
                i = 0;
                while (i < list_len && card_compare(card, cards[i]) != 0)
                begin
                    i++;
                end
                if (i < list_len)
                begin
                    for (j = i; j + 1 < list_len; j++)
                    begin
                        cards[j] = cards[j+1];
                    end
                    list_len--;
                    r.ok    = 1'b1;
                    removed = 1;
                end
            end
            FN_REMOVE_ALL:
            begin
                // compact the survivors towards the head
                j = 0;
                for (i = 0; i < list_len; i++)
                begin
                    if (card_compare(card, cards[i]) == 0)
                    begin
                        removed++;
                    end
                    else
                    begin
                        cards[j] = cards[i];
                        j++;
                    end
                end
                list_len = j;
                r.ok     = (removed != 0);
            end
            FN_READ:
            begin
                if (int'(c.position) < list_len)
                begin
                    r.ok         = 1'b1;
                    r.read_value = cards[c.position].value;
                    r.read_suit  = cards[c.position].suit;
                end
            end
            default: ;
        endcase
        r.entry_count   = COUNT_W'(list_len);
        r.removed_count = COUNT_W'(removed);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            value_order = VALUE_ORDER_RESET;
            suit_order  = SUIT_ORDER_RESET;
            num_ranked  = NUM_RANKED_RESET;
            list_len    = 0;
            awaited_replies.delete();
            outstanding <= 0;
        end
        else
        begin
            // compare a reply with the oldest prediction
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    report_mismatch("reply with no command waiting for it");
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (rsp_data.ok !== want.ok)
                    begin
                        report_mismatch($sformatf("ok %0b, expected %0b",
                                                  rsp_data.ok, want.ok));
                    end
                    if (rsp_data.entry_count !== want.entry_count)
                    begin
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  rsp_data.entry_count, want.entry_count));
                    end
                    if (rsp_data.read_value !== want.read_value)
                    begin
                        report_mismatch($sformatf("read_value %0d, expected %0d",
                                                  rsp_data.read_value, want.read_value));
                    end
                    if (rsp_data.read_suit !== want.read_suit)
                    begin
                        report_mismatch($sformatf("read_suit %0d, expected %0d",
                                                  rsp_data.read_suit, want.read_suit));
                    end
                    if (rsp_data.removed_count !== want.removed_count)
                    begin
                        report_mismatch($sformatf("removed_count %0d, expected %0d",
                                                  rsp_data.removed_count, want.removed_count));
                    end
                end
                replies_seen++;
            end

            // follow register writes
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_VALUE_ORDER: value_order = cfg_data[VORDER_W-1:0];
                    REG_SUIT_ORDER:  suit_order  = cfg_data[SORDER_W-1:0];
                    REG_NUM_RANKED:  num_ranked  = cfg_data[NRV_W-1:0];
                    default: ;
                endcase
            end

            // predict the reply of an accepted command
            if (cmd_valid && cmd_ready)
            begin
                awaited_replies.push_back(apply_list_op(cmd_data));
            end
            outstanding <= awaited_replies.size();
        end
    end

endmodule

### test/tb_ranked_sorted_card_list.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_ranked_sorted_card_list
// Drives the sorted card list with a directed opening and then phases of
// random commands under several rankings, extremes among them, with bursty
// commands and a stalling response side. Checking is left to the checker
// instance; this module makes stimulus, runs the watchdog and gives the verdict.
// ============================================================================

module tb_ranked_sorted_card_list;
    import rscl_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int CARD_HISTORY = 64;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_e;

    logic                   clk   = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int unsigned            outstanding;
    int unsigned            mismatches;
    int unsigned            idle_cycles = 0;
    bit                     hold_off_req = 1'b0;
    card_t                  inserted_cards [$];

    rscl_cmd_if cmd_ch ();
    rscl_rsp_if rsp_ch ();

    ranked_sorted_card_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    card_order_checker list_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_ch.valid),
        .cmd_ready   (cmd_ch.ready),
        .cmd_data    (cmd_ch.data),
        .rsp_valid   (rsp_ch.valid),
        .rsp_ready   (rsp_ch.ready),
        .rsp_data    (rsp_ch.data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_ranked_sorted_card_list: FAIL");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // response side: stall modes of random span, plus a long hold on request
    initial
    begin : reply_side
        stall_mode_e mode;
        int          span;
        int          tick;
        rsp_ch.ready = 1'b0;
        tick         = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = stall_mode_e'($urandom_range(0, 3));
            span = $urandom_range(40, 300);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                if (hold_off_req)
                begin
                    hold_off_req = 1'b0;
                    rsp_ch.ready <= 1'b0;
                    repeat (LONG_HOLD - 1) @(negedge clk);
                end
                else
                begin
                    case (mode)
                        STALL_NONE:  rsp_ch.ready <= 1'b1;
                        STALL_HALF:  rsp_ch.ready <= 1'($urandom_range(0, 1));
                        STALL_HEAVY: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
                        default:     rsp_ch.ready <= ((tick % 7) < 3);
                    endcase
                end
            end
        end
    end

    function automatic cmd_t make_cmd(input logic [FUNC_W-1:0]  func,
                                      input logic [VALUE_W-1:0] value,
                                      input logic [SUIT_W-1:0]  suit,
                                      input logic [POS_W-1:0]   pos);
        cmd_t c;
        c.func       = func;
        c.card_value = value;
        c.card_suit  = suit;
        c.position   = pos;
        return c;
    endfunction

    // random command; removals mostly aim at cards inserted earlier
    function automatic cmd_t random_cmd(input int ins_pct, input int rm1_pct, input int rma_pct);
        cmd_t  c;
        card_t pick;
        int    roll;
        roll         = $urandom_range(0, 99);
        c.card_value = VALUE_W'($urandom_range(0, 15));
        c.card_suit  = SUIT_W'($urandom_range(0, 3));
        c.position   = POS_W'($urandom_range(0, 1) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, 15));
        if (roll < ins_pct)
        begin
            c.func = FN_INSERT;
        end
        else if (roll < ins_pct + rm1_pct)
        begin
            c.func = FN_REMOVE_ONE;
        end
        else if (roll < ins_pct + rm1_pct + rma_pct)
        begin
            c.func = FN_REMOVE_ALL;
        end
        else
        begin
            c.func = FN_READ;
        end
        if ((c.func == FN_REMOVE_ONE || c.func == FN_REMOVE_ALL) &&
            inserted_cards.size() != 0 && $urandom_range(0, 3) != 0)
        begin
            pick         = inserted_cards[$urandom_range(0, inserted_cards.size() - 1)];
            c.card_value = pick.value;
            c.card_suit  = pick.suit;
        end
        return c;
    endfunction

    // register word with random bits above the field
    function automatic logic [CFG_DATA_W-1:0] noisy_word(input logic [CFG_DATA_W-1:0] field,
                                                         input int bits);
        logic [CFG_DATA_W-1:0] word;
        logic [CFG_DATA_W-1:0] mask;
        word = CFG_DATA_W'({$urandom, $urandom});
        mask = (CFG_DATA_W'(1) << bits) - 1'b1;
        return (word & ~mask) | (field & mask);
    endfunction

    // offer one item and hold it until accepted
    task automatic send_cmd(input cmd_t c);
        card_t card;
        @(negedge clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        if (c.func == FN_INSERT)
        begin
            card.value = c.card_value;
            card.suit  = c.card_suit;
            inserted_cards.push_back(card);
            if (inserted_cards.size() > CARD_HISTORY)
            begin
                void'(inserted_cards.pop_front());
            end
        end
    endtask

    task automatic go_idle(input int cycles);
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // stop offering until every reply is in
    task automatic drain_replies();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0]  data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_ranking(input logic [VORDER_W-1:0] vorder,
                               input logic [SORDER_W-1:0] sorder,
                               input logic [NRV_W-1:0]    nranked);
        write_reg(REG_VALUE_ORDER, CFG_DATA_W'(vorder));
        write_reg(REG_SUIT_ORDER, noisy_word(CFG_DATA_W'(sorder), SORDER_W));
        write_reg(REG_NUM_RANKED, noisy_word(CFG_DATA_W'(nranked), NRV_W));
    endtask

    // random commands in bursts; optional long reply hold and full pause
    task automatic run_phase(input int items, input int ins_pct, input int rm1_pct,
                             input int rma_pct, input int hold_at, input int pause_at);
        int burst_left;
        int k;
        burst_left = $urandom_range(1, 40);
        for (k = 0; k < items; k++)
        begin
            if (k == hold_at)
            begin
                hold_off_req = 1'b1;
            end
            if (k == pause_at)
            begin
                drain_replies();
            end
            if (burst_left == 0)
            begin
                go_idle(($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                                    : $urandom_range(1, 8));
                burst_left = $urandom_range(1, 40);
            end
            send_cmd(random_cmd(ins_pct, rm1_pct, rma_pct));
            burst_left--;
        end
    endtask

    initial
    begin
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list: read, remove and remove-all find nothing
        send_cmd(make_cmd(FN_READ, 4'd0, 2'd0, 6'd0));
        send_cmd(make_cmd(FN_REMOVE_ONE, 4'd5, 2'd1, 6'd0));
        send_cmd(make_cmd(FN_REMOVE_ALL, 4'd5, 2'd1, 6'd63));
        // extreme and unranked value codes, equal values split by suit
        send_cmd(make_cmd(FN_INSERT, 4'd0, 2'd0, 6'd0));
        send_cmd(make_cmd(FN_INSERT, 4'd15, 2'd3, 6'd63));
        send_cmd(make_cmd(FN_INSERT, 4'd13, 2'd2, 6'd0));
        send_cmd(make_cmd(FN_INSERT, 4'd14, 2'd1, 6'd0));
        send_cmd(make_cmd(FN_INSERT, 4'd12, 2'd3, 6'd0));
        send_cmd(make_cmd(FN_INSERT, 4'd5, 2'd1, 6'd0));
        send_cmd(make_cmd(FN_INSERT, 4'd5, 2'd2, 6'd0));
        send_cmd(make_cmd(FN_INSERT, 4'd5, 2'd1, 6'd0));
        // reads inside and beyond the list
        send_cmd(make_cmd(FN_READ, 4'd0, 2'd0, 6'd0));
        send_cmd(make_cmd(FN_READ, 4'd0, 2'd0, 6'd3));
        send_cmd(make_cmd(FN_READ, 4'd0, 2'd0, 6'd7));
        send_cmd(make_cmd(FN_READ, 4'd15, 2'd3, 6'd63));
        send_cmd(make_cmd(FN_READ, 4'd0, 2'd0, 6'd42));
        // removals with and without a match
        send_cmd(make_cmd(FN_REMOVE_ONE, 4'd5, 2'd1, 6'd0));
        send_cmd(make_cmd(FN_REMOVE_ONE, 4'd9, 2'd0, 6'd0));
        send_cmd(make_cmd(FN_REMOVE_ALL, 4'd14, 2'd0, 6'd0));
        send_cmd(make_cmd(FN_REMOVE_ALL, 4'd5, 2'd2, 6'd21));
        send_cmd(make_cmd(FN_READ, 4'd0, 2'd0, 6'd1));
        send_cmd(make_cmd(FN_READ, 4'd0, 2'd0, 6'd2));

        // default ranking, insert heavy so the list fills and rejects
        run_phase(200, 85, 5, 2, -1, -1);

        // random value order, reversed suits, stray register index
        drain_replies();
        set_ranking(VORDER_W'({$urandom, $urandom}), 8'h1B, 4'd13);
        write_reg(2'd3, CFG_DATA_W'({$urandom, $urandom}));
        run_phase(200, 30, 30, 10, -1, -1);

        // all-zero ranking: every card compares equal
        drain_replies();
        set_ranking('0, 8'h00, 4'd0);
        run_phase(150, 50, 20, 15, -1, -1);

        // all-ones tables, count above the slots that exist
        drain_replies();
        set_ranking('1, 8'hFF, 4'd15);
        run_phase(150, 80, 5, 5, -1, -1);

        // random tables, count of fourteen, pause midway
        drain_replies();
        set_ranking(VORDER_W'({$urandom, $urandom}), SORDER_W'($urandom), 4'd14);
        run_phase(200, 40, 25, 10, -1, 100);

        // random tables, partial ranking, removal heavy
        drain_replies();
        set_ranking(VORDER_W'({$urandom, $urandom}), SORDER_W'($urandom),
                    NRV_W'($urandom_range(1, 12)));
        run_phase(200, 25, 35, 15, -1, -1);

        // back to the reset ranking, long reply hold midway
        drain_replies();
        set_ranking(VALUE_ORDER_RESET, SUIT_ORDER_RESET, NUM_RANKED_RESET);
        run_phase(250, 45, 25, 10, 120, -1);

        drain_replies();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("tb_ranked_sorted_card_list: PASS");
        end
        else
        begin
            $display("tb_ranked_sorted_card_list: FAIL");
        end
        $finish;
    end

endmodule
